// ----- sv/ifmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared types and constants for the integer field formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package ifmt_pkg;

  localparam int MAX_WIDTH  = 509;
  localparam int NDIG       = 22;
  localparam int SR_W       = 4 * NDIG;
  localparam int VAL_W      = 64;
  localparam int PTR_DIGITS = 8;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } base_t;

  typedef enum logic [2:0] {
    T_IDLE,
    T_SETUP,
    T_CONV,
    T_PLAN,
    T_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_SHIFT,
    C_SCAN
  } conv_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_RUN,
    E_EMPTY
  } emit_state_t;

  typedef enum logic [2:0] {
    PH_PADL,
    PH_PRE0,
    PH_PRE1,
    PH_ZERO,
    PH_DIG,
    PH_PADR
  } phase_t;

  typedef struct packed {
    logic [8:0] padl;
    logic [8:0] padr;
    logic [8:0] zeros;
    logic [4:0] ndig;
    logic [1:0] npre;
    logic [7:0] pre0;
    logic [7:0] pre1;
    logic       upper;
  } plan_t;

endpackage

`default_nettype wire

// ----- sv/ifmt_conv.sv -----
// ----------------------------------------------------------------------------
// Digit converter
// Shifts the magnitude in one bit per cycle, with BCD correction for decimal,
// then scans the digit register to count the significant digits.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmt_conv (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [63:0]              x,
  input  wire ifmt_pkg::base_t          base,
  input  wire logic [4:0]               rd_idx,
  output logic [3:0]                    rd_digit,
  output logic [4:0]                    ndig,
  output logic                          done
);
  import ifmt_pkg::*;

  conv_state_t      state_r, state_nxt;
  logic [SR_W-1:0]  sr_r, sr_nxt;
  logic [63:0]      src_r, src_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [4:0]       scan_r, scan_nxt;
  logic [4:0]       ndig_r, ndig_nxt;
  base_t            base_r, base_nxt;
  logic [4:0]       sel_idx;
  logic [SR_W-1:0]  adj;

  function automatic logic [3:0] digit_at(logic [SR_W-1:0] sr, base_t b, logic [4:0] i);
    logic [3:0] d;
    if (b == BASE_OCT) begin
      d = {1'b0, sr[7'(i) * 7'd3 +: 3]};
    end else begin
      d = sr[{i, 2'b00} +: 4];
    end
    return d;
  endfunction

  assign sel_idx  = (state_r == C_SCAN) ? scan_r : rd_idx;
  assign rd_digit = digit_at(sr_r, base_r, sel_idx);
  assign ndig     = ndig_r;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      adj[4*k +: 4] = sr_r[4*k +: 4];
      if (base_r == BASE_DEC && sr_r[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = sr_r[4*k +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sr_nxt    = sr_r;
    src_nxt   = src_r;
    cnt_nxt   = cnt_r;
    scan_nxt  = scan_r;
    ndig_nxt  = ndig_r;
    base_nxt  = base_r;
    done      = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          sr_nxt    = '0;
          src_nxt   = x;
          base_nxt  = base;
          cnt_nxt   = '0;
          state_nxt = C_SHIFT;
        end
      end
      C_SHIFT: begin
        sr_nxt  = {adj[SR_W-2:0], src_r[63]};
        src_nxt = {src_r[62:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          scan_nxt  = '0;
          ndig_nxt  = 5'd1;
          state_nxt = C_SCAN;
        end
      end
      C_SCAN: begin
        if (rd_digit != 4'd0) begin
          ndig_nxt = scan_r + 5'd1;
        end
        scan_nxt = scan_r + 5'd1;
        if (scan_r == 5'(NDIG - 1)) begin
          done      = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sr_r   <= sr_nxt;
    src_r  <= src_nxt;
    cnt_r  <= cnt_nxt;
    scan_r <= scan_nxt;
    ndig_r <= ndig_nxt;
    base_r <= base_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/ifmt_emit.sv -----
// ----------------------------------------------------------------------------
// Run emitter
// Walks the pad, prefix, zero, digit and pad phases and presents one run per
// word through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ifmt_emit (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire ifmt_pkg::plan_t plan,
  output logic [4:0]           rd_idx,
  input  wire logic [3:0]      rd_digit,
  output logic                 busy,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [23:0]          out_tdata,  // character[7:0], run_length[16:8]
  output logic                 out_tlast
);
  import ifmt_pkg::*;

  emit_state_t state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  logic [7:0]  chr_r, chr_nxt;
  logic [8:0]  len_r, len_nxt;
  logic        last_r, last_nxt;
  logic [5:0]  mask;
  logic        first_found, next_found, slot_free;
  phase_t      first_ph, next_ph;
  logic [7:0]  dig_chr;

  assign mask = {plan.padr != 9'd0, plan.ndig != 5'd0, plan.zeros != 9'd0,
                 plan.npre == 2'd2, plan.npre != 2'd0, plan.padl != 9'd0};

  always_comb begin
    first_found = 1'b0;
    first_ph    = PH_PADL;
    next_found  = 1'b0;
    next_ph     = PH_PADL;
    for (int j = 5; j >= 0; j--) begin
      if (mask[j]) begin
        first_found = 1'b1;
        first_ph    = phase_t'(3'(j));
        if (j > int'(phase_r)) begin
          next_found = 1'b1;
          next_ph    = phase_t'(3'(j));
        end
      end
    end
  end

  always_comb begin
    if (rd_digit < 4'd10) begin
      dig_chr = 8'h30 + {4'd0, rd_digit};
    end else begin
      dig_chr = (plan.upper ? 8'h41 : 8'h61) + {4'd0, rd_digit} - 8'd10;
    end
  end

  assign slot_free  = !vld_r || out_tready;
  assign rd_idx     = idx_r;
  assign busy       = (state_r != E_IDLE);
  assign out_tvalid = vld_r;
  assign out_tdata  = {7'd0, len_r, chr_r};
  assign out_tlast  = last_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r && !out_tready;
    chr_nxt   = chr_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    unique case (state_r)
      E_IDLE: begin
        if (start) begin
          idx_nxt   = plan.ndig - 5'd1;
          phase_nxt = first_ph;
          state_nxt = first_found ? E_RUN : E_EMPTY;
        end
      end
      E_RUN: begin
        if (slot_free) begin
          vld_nxt  = 1'b1;
          last_nxt = !next_found;
          unique case (phase_r)
            PH_PADL: begin
              chr_nxt = 8'h20;
              len_nxt = plan.padl;
            end
            PH_PRE0: begin
              chr_nxt = plan.pre0;
              len_nxt = 9'd1;
            end
            PH_PRE1: begin
              chr_nxt = plan.pre1;
              len_nxt = 9'd1;
            end
            PH_ZERO: begin
              chr_nxt = 8'h30;
              len_nxt = plan.zeros;
            end
            PH_DIG: begin
              chr_nxt  = dig_chr;
              len_nxt  = 9'd1;
              last_nxt = (idx_r == 5'd0) && !next_found;
            end
            PH_PADR: begin
              chr_nxt = 8'h20;
              len_nxt = plan.padr;
            end
            default: begin
              chr_nxt = 8'h20;
              len_nxt = 9'd0;
            end
          endcase
          if (phase_r == PH_DIG && idx_r != 5'd0) begin
            idx_nxt = idx_r - 5'd1;
          end else if (next_found) begin
            phase_nxt = next_ph;
          end else begin
            state_nxt = E_IDLE;
          end
        end
      end
      E_EMPTY: begin
        if (slot_free) begin
          vld_nxt   = 1'b1;
          chr_nxt   = 8'd0;
          len_nxt   = 9'd0;
          last_nxt  = 1'b1;
          state_nxt = E_IDLE;
        end
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    phase_r <= phase_nxt;
    idx_r   <= idx_nxt;
    chr_r   <= chr_nxt;
    len_r   <= len_nxt;
    last_r  <= last_nxt;
  end

endmodule

`default_nettype wire

// ----- sv/integer_field_formatter.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter
// Turns one parsed integer conversion into runs of repeated ASCII characters.
// ----------------------------------------------------------------------------
// Flow: a setup step, bit-serial conversion, a digit scan, a planning step and
// the output register lie between the word being taken and the first run word;
// the run words then follow one per cycle while out_tready is high (up to 25).
// One field is in work at a time: the next word is taken only after the
// emitter has issued the last run word of the previous field.
// Reset is synchronous and active low; it clears all control state.
`default_nettype none

module integer_field_formatter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // kind[2:0], size_mod[4:3], left_justify[5], plus_sign[6], space_sign[7],
  // alternate[8], zero_pad[9], field_width[18:10], precision[28:19],
  // value[92:29]
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // character[7:0], run_length[16:8]
  output logic [23:0]      out_tdata,
  output logic             out_tlast
);
  import ifmt_pkg::*;

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEXL = 3'd3;
  localparam logic [2:0] KIND_HEXU = 3'd4;
  localparam logic [2:0] KIND_PTR  = 3'd5;
  localparam logic [1:0] SIZE_SHORT = 2'd1;

  top_state_t   state_r, state_nxt;
  logic [95:0]  in_r;
  logic [2:0]   kind;
  logic [1:0]   sm;
  logic         left, plus, space, alt, zpad;
  logic [8:0]   fw;
  logic [9:0]   prec_in;
  logic [63:0]  val;

  logic signed [11:0] prec_r, prec_s;
  logic         conv_r, conv_s;
  logic         ptr_r, ptr_s;
  logic         upper_s, upper_r;
  logic [1:0]   npre_r, npre_s;
  logic [7:0]   pre0_r, pre0_s, pre1_r, pre1_s;
  logic [63:0]  x_s, xs;
  logic         neg;
  base_t        base_s;
  plan_t        plan_r, plan_nxt;

  logic         conv_start, conv_done, emit_start, emit_busy;
  logic [4:0]   conv_ndig, rd_idx;
  logic [3:0]   rd_digit;

  logic signed [11:0] w_s, nd_s, np_s, z_s, pad_s;

  assign kind    = in_r[2:0];
  assign sm      = in_r[4:3];
  assign left    = in_r[5];
  assign plus    = in_r[6];
  assign space   = in_r[7];
  assign alt     = in_r[8];
  assign zpad    = in_r[9];
  assign fw      = in_r[18:10];
  assign prec_in = in_r[28:19];
  assign val     = in_r[92:29];

  assign in_tready  = (state_r == T_IDLE);
  assign conv_start = (state_r == T_SETUP);
  assign emit_start = (state_r == T_PLAN);

  always_comb begin
    prec_s = {{2{prec_in[9]}}, prec_in};
    if (prec_s > 12'(MAX_WIDTH)) begin
      prec_s = 12'(MAX_WIDTH);
    end
    conv_s  = 1'b1;
    ptr_s   = 1'b0;
    upper_s = 1'b0;
    npre_s  = 2'd0;
    pre0_s  = 8'h30;
    pre1_s  = 8'h78;
    base_s  = BASE_DEC;
    x_s     = '0;
    xs      = '0;
    neg     = 1'b0;
    unique case (kind)
      KIND_SDEC: begin
        if (prec_s < 12'sd0) begin
          prec_s = 12'sd1;
        end
        xs  = sm[1] ? val : {{32{val[31]}}, val[31:0]};
        neg = sm[1] ? val[63] : val[31];
        if (xs == 64'd0 && prec_s == 12'sd0) begin
          conv_s = 1'b0;
        end else begin
          x_s = neg ? (64'd0 - xs) : xs;
          if (neg) begin
            npre_s = 2'd1;
            pre0_s = 8'h2D;
          end else if (plus) begin
            npre_s = 2'd1;
            pre0_s = 8'h2B;
          end else if (space) begin
            npre_s = 2'd1;
            pre0_s = 8'h20;
          end
          if (sm == SIZE_SHORT) begin
            x_s = {48'd0, x_s[15:0]};
          end else if (!sm[1]) begin
            x_s = {32'd0, x_s[31:0]};
          end
        end
      end
      KIND_UDEC, KIND_OCT, KIND_HEXL, KIND_HEXU: begin
        if (prec_s < 12'sd0) begin
          prec_s = 12'sd1;
        end
        xs = sm[1] ? val : {32'd0, val[31:0]};
        if (xs == 64'd0 && prec_s == 12'sd0) begin
          conv_s = 1'b0;
        end else begin
          upper_s = (kind == KIND_HEXU);
          base_s  = (kind == KIND_UDEC) ? BASE_DEC :
                    (kind == KIND_OCT) ? BASE_OCT : BASE_HEX;
          if (alt) begin
            if (kind == KIND_OCT) begin
              npre_s = 2'd1;
              prec_s = prec_s - 12'sd1;
            end else if (kind != KIND_UDEC) begin
              npre_s = 2'd2;
              pre1_s = upper_s ? 8'h58 : 8'h78;
            end
          end
          x_s = (sm == SIZE_SHORT) ? {48'd0, xs[15:0]} : xs;
        end
      end
      KIND_PTR: begin
        x_s    = {32'd0, val[31:0]};
        base_s = BASE_HEX;
        ptr_s  = 1'b1;
      end
      default: conv_s = 1'b0;
    endcase
  end

  always_comb begin
    w_s  = (fw > 9'(MAX_WIDTH)) ? 12'(MAX_WIDTH) : {3'd0, fw};
    nd_s = conv_r ? {7'd0, conv_ndig} : 12'sd0;
    np_s = {10'd0, npre_r};
    z_s  = 12'sd0;
    if (!conv_r) begin
      z_s = 12'sd0;
    end else if (ptr_r) begin
      z_s = 12'(PTR_DIGITS) - nd_s;
    end else if (zpad && !left) begin
      z_s = w_s - np_s - nd_s;
    end else if (prec_r > 12'sd0) begin
      z_s = prec_r - nd_s;
    end
    if (z_s < 12'sd0) begin
      z_s = 12'sd0;
    end
    pad_s          = w_s - np_s - z_s - nd_s;
    plan_nxt.padl  = (!left && pad_s > 12'sd0) ? pad_s[8:0] : 9'd0;
    plan_nxt.padr  = (left && pad_s > 12'sd0) ? pad_s[8:0] : 9'd0;
    plan_nxt.zeros = z_s[8:0];
    plan_nxt.ndig  = nd_s[4:0];
    plan_nxt.npre  = npre_r;
    plan_nxt.pre0  = pre0_r;
    plan_nxt.pre1  = pre1_r;
    plan_nxt.upper = upper_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_tvalid) state_nxt = T_SETUP;
      T_SETUP: state_nxt = T_CONV;
      T_CONV:  if (conv_done) state_nxt = T_PLAN;
      T_PLAN:  state_nxt = T_EMIT;
      T_EMIT:  if (!emit_busy) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (in_tvalid && in_tready) begin
      in_r <= in_tdata;
    end
    if (state_r == T_SETUP) begin
      prec_r  <= prec_s;
      conv_r  <= conv_s;
      ptr_r   <= ptr_s;
      upper_r <= upper_s;
      npre_r  <= npre_s;
      pre0_r  <= pre0_s;
      pre1_r  <= pre1_s;
    end
    if (state_r == T_PLAN) begin
      plan_r <= plan_nxt;
    end
  end

  ifmt_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (conv_start),
    .x        (x_s),
    .base     (base_s),
    .rd_idx   (rd_idx),
    .rd_digit (rd_digit),
    .ndig     (conv_ndig),
    .done     (conv_done)
  );

  ifmt_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (emit_start),
    .plan       (plan_nxt),
    .rd_idx     (rd_idx),
    .rd_digit   (rd_digit),
    .busy       (emit_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !emit_busy)
    else $error("input ready while runs are still being emitted");

  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> state_r == T_CONV)
    else $error("converter finished outside the conversion phase");

  a_ndig_range: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |=> (conv_ndig >= 5'd1 && conv_ndig <= 5'(NDIG)))
    else $error("digit count out of range");

  a_plan_held: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == T_EMIT |-> plan_r == plan_nxt)
    else $error("run plan changed while emitting");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Integer field formatter testbench
// Drives conversion specs into the formatter and checks every output run
// against a behavioral predictor, with random idling on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import ifmt_pkg::*;

  localparam logic [2:0] K_SDEC = 3'd0;
  localparam logic [2:0] K_UDEC = 3'd1;
  localparam logic [2:0] K_OCT = 3'd2;
  localparam logic [2:0] K_HEXL = 3'd3;
  localparam logic [2:0] K_HEXU = 3'd4;
  localparam logic [2:0] K_PTR = 3'd5;
  localparam logic [1:0] SZ_PLAIN = 2'd0;
  localparam logic [1:0] SZ_SHORT = 2'd1;
  localparam logic [1:0] SZ_LONG = 2'd2;
  localparam int N_RANDOM = 400;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] size_mod;
    logic left_justify;
    logic plus_sign;
    logic space_sign;
    logic alternate;
    logic zero_pad;
    logic [8:0] field_width;
    logic [9:0] precision;
    logic [63:0] value;
  } spec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [8:0] run_len;
    logic last;
  } run_t;

  typedef struct {
    spec_t spec;
    int nruns;
    run_t runs[3];
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tlast;

  run_t runs_pending[$];
  int mismatches = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  integer_field_formatter i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_run(logic [7:0] c, int len);
    run_t r;
    if (len > 0) begin
      r.ch = c;
      r.run_len = len[8:0];
      r.last = 1'b0;
      runs_pending.push_back(r);
    end
  endfunction

  // Appends the runs that one spec produces to runs_pending.
  function automatic void format_runs(spec_t s);
    int width, prec, npre, ndig, zeros, pad, base, i, start;
    logic [63:0] x;
    logic [7:0] pre[2];
    logic [7:0] dig[32];
    logic neg, upper, ptr, conv;
    run_t r;
    width = s.field_width;
    prec = $signed(s.precision);
    npre = 0; ndig = 0; zeros = 0; base = 10;
    upper = 1'b0; ptr = 1'b0; conv = 1'b1; x = '0;
    start = runs_pending.size();
    if (width > MAX_WIDTH) width = MAX_WIDTH;
    if (prec > MAX_WIDTH) prec = MAX_WIDTH;
    case (s.kind)
      K_SDEC: begin
        if (prec < 0) prec = 1;
        if (s.size_mod >= SZ_LONG) begin
          x = s.value;
          neg = s.value[63];
        end else begin
          neg = s.value[31];
          x = {{32{neg}}, s.value[31:0]};
        end
        if (x == 0 && prec == 0) conv = 1'b0;
        else begin
          if (neg) begin
            pre[npre++] = "-";
            x = -x;
          end else if (s.plus_sign) pre[npre++] = "+";
          else if (s.space_sign) pre[npre++] = " ";
          if (s.size_mod == SZ_SHORT) x &= 64'hFFFF;
          else if (s.size_mod == SZ_PLAIN) x &= 64'hFFFF_FFFF;
        end
      end
      K_UDEC, K_OCT, K_HEXL, K_HEXU: begin
        if (prec < 0) prec = 1;
        x = (s.size_mod >= SZ_LONG) ? s.value : {32'd0, s.value[31:0]};
        if (x == 0 && prec == 0) conv = 1'b0;
        else begin
          base = (s.kind == K_UDEC) ? 10 : (s.kind == K_OCT) ? 8 : 16;
          upper = (s.kind == K_HEXU);
          if (s.alternate) begin
            if (s.kind == K_OCT) begin
              pre[npre++] = "0";
              prec--;
            end else if (s.kind != K_UDEC) begin
              pre[npre++] = "0";
              pre[npre++] = upper ? "X" : "x";
            end
          end
          if (s.size_mod == SZ_SHORT) x &= 64'hFFFF;
        end
      end
      K_PTR: begin
        x = {32'd0, s.value[31:0]};
        base = 16;
        ptr = 1'b1;
      end
      default: conv = 1'b0;
    endcase
    if (conv) begin
      do begin
        int d;
        d = x % base;
        dig[ndig++] = (d < 10) ? 8'(48 + d) : (upper ? 8'(55 + d) : 8'(87 + d));
        x = x / base;
      end while (x != 0 && ndig < 32);
      if (ptr) zeros = (ndig < PTR_DIGITS) ? PTR_DIGITS - ndig : 0;
      else if (s.zero_pad && !s.left_justify) zeros = width - (npre + ndig);
      else if (prec > 0) zeros = prec - ndig;
      if (zeros < 0) zeros = 0;
    end
    pad = width - (npre + zeros + ndig);
    if (!s.left_justify) add_run(" ", pad);
    for (i = 0; i < npre; i++) add_run(pre[i], 1);
    add_run("0", zeros);
    for (i = ndig - 1; i >= 0; i--) add_run(dig[i], 1);
    if (s.left_justify) add_run(" ", pad);
    if (runs_pending.size() == start) begin
      r = '0;
      runs_pending.push_back(r);
    end
    runs_pending[runs_pending.size() - 1].last = 1'b1;
  endfunction

  function automatic spec_t mk(logic [2:0] k, logic [1:0] sz, logic [4:0] flags,
                               int w, int p, logic [63:0] v);
    spec_t s;
    s.kind = k;
    s.size_mod = sz;
    {s.left_justify, s.plus_sign, s.space_sign, s.alternate, s.zero_pad} = flags;
    s.field_width = w[8:0];
    s.precision = p[9:0];
    s.value = v;
    return s;
  endfunction

  function automatic row_t row(spec_t s, int n = 0, run_t r0 = '0, run_t r1 = '0,
                               run_t r2 = '0);
    row_t t;
    t.spec = s;
    t.nruns = n;
    t.runs[0] = r0; t.runs[1] = r1; t.runs[2] = r2;
    return t;
  endfunction

  function automatic spec_t random_spec();
    spec_t s;
    logic [95:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom};
    s = raw[92:0];
    s.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5));
    s.size_mod = 2'($urandom_range(0, 3));
    sel = $urandom_range(0, 9);
    if (sel < 6) s.field_width = 9'($urandom_range(0, 30));
    else if (sel == 9) s.field_width = 9'($urandom_range(500, 511));
    sel = $urandom_range(0, 9);
    if (sel < 4) s.precision = 10'($urandom_range(0, 30));
    else if (sel < 7) s.precision = 10'h3FF;
    else if (sel == 7) s.precision = 10'($urandom_range(500, 511));
    sel = $urandom_range(0, 7);
    if (sel == 0) s.value = '0;
    else if (sel == 1) s.value = 64'($urandom_range(0, 20));
    else if (sel == 2) s.value = {32'($urandom), 1'b1, 31'($urandom)};
    return s;
  endfunction

  task automatic send_spec(spec_t s);
    in_tdata <= {3'd0, s.value, s.precision, s.field_width, s.zero_pad, s.alternate,
                 s.space_sign, s.plus_sign, s.left_justify, s.size_mod, s.kind};
    in_tvalid <= 1'b1;
    format_runs(s);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic check_typed(row_t t);
    int base;
    base = runs_pending.size();
    format_runs(t.spec);
    for (int i = 0; i < t.nruns; i++) begin
      if (runs_pending.size() != base + t.nruns || runs_pending[base + i] != t.runs[i]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("typed row differs from predictor: %h", t.spec);
      end
    end
    while (runs_pending.size() > base) void'(runs_pending.pop_back());
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        run_t got;
        got = {out_tdata[7:0], out_tdata[16:8], out_tlast};
        if (runs_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %h", got);
        end else begin
          run_t exp_run;
          exp_run = runs_pending.pop_front();
          if (got !== exp_run) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
                       exp_run.ch, exp_run.run_len, exp_run.last,
                       got.ch, got.run_len, got.last);
          end
        end
      end
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    row_t rows[$];
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // Rows with typed expectations.
    rows.push_back(row(mk(K_SDEC, SZ_PLAIN, 5'b0, 0, 0, 64'd0), 1, {8'h00, 9'd0, 1'b1}));
    rows.push_back(row(mk(K_UDEC, SZ_PLAIN, 5'b0, 0, -1, 64'd0), 1, {8'h30, 9'd1, 1'b1}));
    rows.push_back(row(mk(3'd6, SZ_PLAIN, 5'b0, 3, -1, 64'd5), 1, {8'h20, 9'd3, 1'b1}));
    rows.push_back(row(mk(3'd7, SZ_PLAIN, 5'b10000, 509, 0, 64'd5), 1,
                       {8'h20, 9'd509, 1'b1}));
    rows.push_back(row(mk(K_HEXL, SZ_PLAIN, 5'b00010, 0, -1, 64'd0), 3,
                       {8'h30, 9'd1, 1'b0}, {8'h78, 9'd1, 1'b0}, {8'h30, 9'd1, 1'b1}));
    rows.push_back(row(mk(K_SDEC, SZ_PLAIN, 5'b0, 0, -1, 64'hFFFF_FFFF), 2,
                       {8'h2D, 9'd1, 1'b0}, {8'h31, 9'd1, 1'b1}));
    // Rows checked by the predictor alone.
    rows.push_back(row(mk(K_SDEC, SZ_LONG, 5'b01000, 0, -1, 64'h8000_0000_0000_0000)));
    rows.push_back(row(mk(K_SDEC, SZ_SHORT, 5'b00100, 10, 5, 64'h7FFF_FFFF)));
    rows.push_back(row(mk(K_SDEC, SZ_SHORT, 5'b00001, 12, 3, 64'h8000_0000)));
    rows.push_back(row(mk(K_UDEC, 2'd3, 5'b10000, 30, -1, '1)));
    rows.push_back(row(mk(K_UDEC, SZ_SHORT, 5'b0, 0, 509, 64'h1_2345)));
    rows.push_back(row(mk(K_OCT, SZ_LONG, 5'b00010, 0, -1, '1)));
    rows.push_back(row(mk(K_OCT, SZ_PLAIN, 5'b00010, 0, 0, 64'd0)));
    rows.push_back(row(mk(K_OCT, SZ_PLAIN, 5'b00010, 6, 4, 64'o17)));
    rows.push_back(row(mk(K_HEXU, SZ_PLAIN, 5'b00011, 16, -1, 64'hDEAD_BEEF)));
    rows.push_back(row(mk(K_HEXL, SZ_LONG, 5'b10011, 20, 2, 64'hABCD_EF01_2345_6789)));
    rows.push_back(row(mk(K_PTR, SZ_LONG, 5'b11111, 12, 20, 64'hFFFF_0000_0000_00AB)));
    rows.push_back(row(mk(K_PTR, SZ_PLAIN, 5'b0, 0, 0, 64'd0)));
    rows.push_back(row(mk(K_SDEC, SZ_PLAIN, 5'b01001, 511, 1023, 64'd42)));
    rows.push_back(row(mk(K_UDEC, SZ_PLAIN, 5'b0, 0, 600, 64'd7)));
    rows.push_back(row(mk(K_SDEC, SZ_PLAIN, 5'b0, 4, -300, 64'd9)));
    foreach (rows[i]) begin
      if (rows[i].nruns > 0) check_typed(rows[i]);
      send_spec(rows[i].spec);
    end
    in_tvalid <= 1'b0;
    while (runs_pending.size() > 0) @(posedge clk);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 60) quiet = 1'b1;
      send_spec(random_spec());
    end
    in_tvalid <= 1'b0;
    while (runs_pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end
endmodule

`default_nettype wire
